### hw/rtl/led_panel_quarter_scan_driver_unit_macros.svh
// Assertion macros for the checker file of the LED panel driver.
// No dependencies; include by bare file name.
`ifndef LED_PANEL_QUARTER_SCAN_DRIVER_UNIT_MACROS_SVH
`define LED_PANEL_QUARTER_SCAN_DRIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, live during reset.
`define LPQS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lpqs_pkg.sv
// Package for the LED panel quarter-scan driver: widths, defaults, types.
// No dependencies.
`timescale 1ns / 1ps

package lpqs_pkg;

   localparam int BYTES_PER_ROW_DEF = 16;
   localparam int SCAN_PHASES_DEF   = 4;

   localparam int ADDR_W = 6;
   localparam int BYTE_W = 8;
   localparam int ROW_W  = 2;
   localparam int FRAME_DEPTH = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [ADDR_W-1:0]       addr;
      logic [BYTE_W-1:0]       data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

### hw/rtl/led_panel_quarter_scan_driver_unit.sv
// Top level of the LED panel quarter-scan driver.
// Depends on lpqs_pkg, lpqs_front and lpqs_back.
//
// Use: the req channel carries write transactions (command 0: store
// req_frame_byte at req_frame_address in the 64-byte frame store) and scan
// ticks (command 1). A write gives no response. A tick gives BYTES_PER_ROW
// response transactions, byte i being frame[i*SCAN_PHASES + phase];
// the final one has rsp_last set and rsp_row_select equal to
// SCAN_PHASES-1-phase (2 bits), zero otherwise. The phase then advances.
// Requests enter a two-entry queue and are carried out in order.
// The first response of a tick passes the queue, the dispatch state, the
// read register and the output register. A write is done by the back
// end in its idle state; a dispatched tick does one frame-memory read
// per cycle through the single read port while the output is not stalled.
// Reset clears the phase, the queue and the per-byte written flags, so the
// frame store reads as zero; no clearing pass is needed.
// A stalled response holds its payload; the read pipeline stops behind it
// and the queue keeps accepting until full.
`timescale 1ns / 1ps

module led_panel_quarter_scan_driver_unit #(
   parameter int BYTES_PER_ROW = lpqs_pkg::BYTES_PER_ROW_DEF,
   parameter int SCAN_PHASES   = lpqs_pkg::SCAN_PHASES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [lpqs_pkg::ADDR_W-1:0] req_frame_address,
   input  logic [lpqs_pkg::BYTE_W-1:0] req_frame_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lpqs_pkg::BYTE_W-1:0] rsp_shift_byte,
   output logic [lpqs_pkg::ROW_W-1:0]  rsp_row_select,
   output logic                        rsp_last
);

   lpqs_pkg::queue_head_type head;
   logic                     pop;

   lpqs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_frame_address (req_frame_address),
      .req_frame_byte    (req_frame_byte),
      .head              (head),
      .pop               (pop)
   );

   lpqs_back #(
      .BYTES_PER_ROW (BYTES_PER_ROW),
      .SCAN_PHASES   (SCAN_PHASES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_row_select (rsp_row_select),
      .rsp_last       (rsp_last)
   );

endmodule

### hw/rtl/lpqs_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on lpqs_pkg.
`timescale 1ns / 1ps

module lpqs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   input  logic [lpqs_pkg::ADDR_W-1:0] req_frame_address,
   input  logic [lpqs_pkg::BYTE_W-1:0] req_frame_byte,
   output lpqs_pkg::queue_head_type    head,
   input  logic                        pop
);

   lpqs_pkg::item_type                 queue_ff [lpqs_pkg::QUEUE_DEPTH];
   logic [lpqs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lpqs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lpqs_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               push;
   logic                               do_pop;
   lpqs_pkg::item_type                 new_item;

   assign req_stall = (count_ff == lpqs_pkg::QCNT_W'(lpqs_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_item.cmd  = lpqs_pkg::cmd_type'(req_command);
      new_item.addr = req_frame_address;
      new_item.data = req_frame_byte;
   end

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = queue_ff[rd_ptr_ff];
   end

endmodule

### hw/rtl/lpqs_back.sv
// Back end: frame memory, scan sequencer and result pipeline.
// Depends on lpqs_pkg.
`timescale 1ns / 1ps

module lpqs_back #(
   parameter int BYTES_PER_ROW = lpqs_pkg::BYTES_PER_ROW_DEF,
   parameter int SCAN_PHASES   = lpqs_pkg::SCAN_PHASES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpqs_pkg::queue_head_type    head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lpqs_pkg::BYTE_W-1:0] rsp_shift_byte,
   output logic [lpqs_pkg::ROW_W-1:0]  rsp_row_select,
   output logic                        rsp_last
);

   localparam int PH_W  = $clog2(SCAN_PHASES);
   localparam int CNT_W = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

   logic [lpqs_pkg::BYTE_W-1:0]  mem [lpqs_pkg::FRAME_DEPTH];
   logic [lpqs_pkg::FRAME_DEPTH-1:0] written_ff;

   lpqs_pkg::back_state_type     state_ff, state_in;
   logic [PH_W-1:0]              phase_ff, phase_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [lpqs_pkg::ADDR_W-1:0]  addr_ff, addr_in;

   logic                         mem_we;
   logic                         issue;
   logic                         is_last;
   logic [lpqs_pkg::ROW_W-1:0]   row_value;

   logic                         rd_valid_ff, rd_valid_in;
   logic [lpqs_pkg::BYTE_W-1:0]  rd_byte_ff;
   logic [lpqs_pkg::ROW_W-1:0]   rd_row_ff;
   logic                         rd_last_ff;
   logic                         move;

   logic                         out_valid_ff, out_valid_in;
   logic [lpqs_pkg::BYTE_W-1:0]  out_byte_ff;
   logic [lpqs_pkg::ROW_W-1:0]   out_row_ff;
   logic                         out_last_ff;

   assign move    = rd_valid_ff && (!out_valid_ff || !rsp_stall);
   assign is_last = (cnt_ff == CNT_W'(BYTES_PER_ROW - 1));
   assign row_value = lpqs_pkg::ROW_W'(SCAN_PHASES - 1) - lpqs_pkg::ROW_W'(phase_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      pop      = 1'b0;
      mem_we   = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         lpqs_pkg::BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.cmd == lpqs_pkg::CMD_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  cnt_in   = '0;
                  addr_in  = lpqs_pkg::ADDR_W'(phase_ff);
                  state_in = lpqs_pkg::BK_SCAN;
               end
            end
         end
         lpqs_pkg::BK_SCAN: begin
            issue = !rd_valid_ff || move;
            if (issue) begin
               addr_in = addr_ff + lpqs_pkg::ADDR_W'(SCAN_PHASES);
               cnt_in  = cnt_ff + 1'b1;
               if (is_last) begin
                  phase_in = (phase_ff == PH_W'(SCAN_PHASES - 1)) ? '0 : phase_ff + 1'b1;
                  state_in = lpqs_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = lpqs_pkg::BK_IDLE;
         end
      endcase
   end

   assign rd_valid_in  = issue || (rd_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpqs_pkg::BK_IDLE;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
         if (mem_we) begin
            written_ff[head.item.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[head.item.addr] <= head.item.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_byte_ff <= written_ff[addr_ff] ? mem[addr_ff] : '0;
         rd_row_ff  <= is_last ? row_value : '0;
         rd_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_byte_ff <= rd_byte_ff;
         out_row_ff  <= rd_row_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_shift_byte = out_byte_ff;
   assign rsp_row_select = out_row_ff;
   assign rsp_last       = out_last_ff;

endmodule

### hw/rtl/lpqs_checker.sv
// Port-level checker for the LED panel driver, bound to the top level.
// Depends on lpqs_pkg and led_panel_quarter_scan_driver_unit_macros.svh.
`timescale 1ns / 1ps
`include "led_panel_quarter_scan_driver_unit_macros.svh"

module lpqs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [lpqs_pkg::BYTE_W-1:0] rsp_shift_byte,
   input logic [lpqs_pkg::ROW_W-1:0]  rsp_row_select,
   input logic                        rsp_last
);

   `LPQS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_shift_byte) && $stable(rsp_row_select) && $stable(rsp_last), "stalled response changed")
   `LPQS_ASSERT_NOW(a_row_on_last, clock, reset, rsp_valid && !rsp_last, rsp_row_select == '0, "row select set before last byte")
   `LPQS_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !req_stall && !rsp_valid, "not idle after reset")

endmodule

bind led_panel_quarter_scan_driver_unit lpqs_checker u_lpqs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_shift_byte (rsp_shift_byte),
   .rsp_row_select (rsp_row_select),
   .rsp_last       (rsp_last)
);
